FILE: src/mlfs_pkg.sv
`default_nettype none

package mlfs_pkg;

    typedef enum logic [1:0] {
        LVL_HIGH   = 2'd0,
        LVL_MIDDLE = 2'd1,
        LVL_LOW    = 2'd2
    } level_t;

    localparam int unsigned NUM_LEVELS = 3;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [1:0] CFG_HIGH_QUANTUM   = 2'd0;
    localparam logic [1:0] CFG_MIDDLE_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_LOW_QUANTUM    = 2'd2;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] remaining;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: src/mlfs_cell.sv
`default_nettype none

module mlfs_cell (
    input  wire logic            aclk,
    input  wire logic            load,
    input  wire logic            shift,
    input  wire mlfs_pkg::entry_t load_data,
    input  wire mlfs_pkg::entry_t next_data,
    output mlfs_pkg::entry_t     data
);
    import mlfs_pkg::*;

    entry_t data_reg;

    // a load wins over the shift toward the head
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end else if (shift) begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: src/mlfs_queue.sv
`default_nettype none

module mlfs_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mlfs_pkg::queue_ctrl_t ctrl,
    input  wire mlfs_pkg::entry_t      push_data,
    output mlfs_pkg::entry_t           head_data,
    output mlfs_pkg::queue_status_t    status
);
    import mlfs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] target;
    logic          full;
    logic          push_ok;
    entry_t        cell_data [DEPTH];

    assign full    = (count_reg == CW'(DEPTH));
    // a pop in the same beat frees a slot for the push
    assign push_ok = ctrl.push && (ctrl.pop || !full);
    assign target  = ctrl.pop ? (count_reg - CW'(1)) : count_reg;

    always_comb begin
        count_next = count_reg;
        unique case ({push_ok, ctrl.pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t nxt;
        if (i == DEPTH - 1) begin : g_last
            assign nxt = cell_data[i];
        end else begin : g_mid
            assign nxt = cell_data[i+1];
        end
        mlfs_cell u_cell (
            .aclk      (aclk),
            .load      (push_ok && (target == CW'(i))),
            .shift     (ctrl.pop),
            .load_data (push_data),
            .next_data (nxt),
            .data      (cell_data[i])
        );
    end

    assign head_data    = cell_data[0];
    assign status.empty = (count_reg == '0);
    assign status.full  = full;

endmodule

`default_nettype wire

FILE: src/multilevel_feedback_scheduler.sv
`default_nettype none

// Channel | Direction | Ports                                              | Beat
// s_      | in        | s_req_type s_job_id s_service_slices s_job_level   | arrival or tick
// m_      | out       | m_served_id m_idle m_served_level m_job_done        | one per tick
//         |           | m_overflow                                          |
// cfg_    | in        | cfg_index cfg_data                                  | quantum write
//
// An arrival is loaded into the first free cell of its queue's row. A tick
// serves the job on the server or, if it is free, the head (cell 0) of the
// highest non-empty queue, and updates the server in the same cycle.
// The result of a tick sits in the output register; a new beat is taken while
// that register is empty or being drained, so a stalled m_ side stalls s_.
// Reset (aresetn low, synchronous) empties all queues, frees the server, clears
// the overflow flag and loads quanta 1, 2, 3. No clearing pass is needed.

module multilevel_feedback_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [7:0] s_job_id,
    input  wire logic [7:0] s_service_slices,
    input  wire logic [1:0] s_job_level,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_served_id,
    output logic            m_idle,
    output logic [1:0]      m_served_level,
    output logic            m_job_done,
    output logic            m_overflow,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data
);
    import mlfs_pkg::*;

    // quantum registers
    logic [3:0] high_q_reg, middle_q_reg, low_q_reg;

    // server state
    logic       busy_reg, busy_next;
    logic [7:0] cur_id_reg, cur_id_next;
    logic [7:0] cur_rem_reg, cur_rem_next;
    level_t     cur_lvl_reg, cur_lvl_next;
    logic [3:0] used_reg, used_next;
    logic       ovf_reg, ovf_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_id_reg;
    logic       m_idle_reg;
    level_t     m_lvl_reg;
    logic       m_done_reg;
    logic       m_ovf_reg;

    // queue interface, one slot per level
    queue_ctrl_t   q_ctrl      [NUM_LEVELS];
    entry_t        q_push_data [NUM_LEVELS];
    entry_t        q_head      [NUM_LEVELS];
    queue_status_t q_stat      [NUM_LEVELS];

    logic       in_accept;
    logic       res_load;
    logic       res_idle;
    logic [7:0] res_id;
    level_t     res_lvl;
    logic       res_done;
    level_t     arr_lvl;
    level_t     sel_lvl;
    level_t     dem_lvl;
    logic       serving;
    logic [7:0] job_id_w, job_rem_w;
    level_t     job_lvl_w;
    logic [3:0] used_w, used_inc;
    logic [3:0] quantum_w;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
        mlfs_queue #(
            .DEPTH (QUEUE_DEPTH)
        ) u_queue (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (q_ctrl[l]),
            .push_data (q_push_data[l]),
            .head_data (q_head[l]),
            .status    (q_stat[l])
        );
    end

    always_comb begin
        busy_next    = busy_reg;
        cur_id_next  = cur_id_reg;
        cur_rem_next = cur_rem_reg;
        cur_lvl_next = cur_lvl_reg;
        used_next    = used_reg;
        ovf_next     = ovf_reg;
        res_load     = 1'b0;
        res_idle     = 1'b0;
        res_id       = '0;
        res_lvl      = LVL_HIGH;
        res_done     = 1'b0;
        arr_lvl      = LVL_LOW;
        sel_lvl      = LVL_HIGH;
        dem_lvl      = LVL_LOW;
        serving      = 1'b0;
        job_id_w     = cur_id_reg;
        job_rem_w    = cur_rem_reg;
        job_lvl_w    = cur_lvl_reg;
        used_w       = used_reg;
        used_inc     = '0;
        quantum_w    = low_q_reg;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            q_ctrl[l]      = '0;
            q_push_data[l] = '{id: s_job_id, remaining: s_service_slices};
        end

        if (in_accept) begin
            if (s_req_type == REQ_ARRIVAL) begin
                // level code 3 falls back to the low queue
                unique case (s_job_level)
                    2'd0:    arr_lvl = LVL_HIGH;
                    2'd1:    arr_lvl = LVL_MIDDLE;
                    default: arr_lvl = LVL_LOW;
                endcase
                q_ctrl[arr_lvl].push = 1'b1;
                if (q_stat[arr_lvl].full) begin
                    ovf_next = 1'b1;     // drop the arrival
                end
            end else begin
                res_load = 1'b1;
                serving  = busy_reg;
                if (!busy_reg) begin
                    // pick the highest level with work waiting
                    priority if (!q_stat[LVL_HIGH].empty) begin
                        sel_lvl = LVL_HIGH;
                        serving = 1'b1;
                    end else if (!q_stat[LVL_MIDDLE].empty) begin
                        sel_lvl = LVL_MIDDLE;
                        serving = 1'b1;
                    end else if (!q_stat[LVL_LOW].empty) begin
                        sel_lvl = LVL_LOW;
                        serving = 1'b1;
                    end else begin
                        res_idle = 1'b1;
                    end
                    if (serving) begin
                        q_ctrl[sel_lvl].pop = 1'b1;
                        job_id_w  = q_head[sel_lvl].id;
                        job_rem_w = q_head[sel_lvl].remaining;
                        job_lvl_w = sel_lvl;
                        used_w    = '0;
                    end
                end

                if (serving) begin
                    used_inc = used_w + 4'd1;
                    unique case (job_lvl_w)
                        LVL_HIGH:   quantum_w = high_q_reg;
                        LVL_MIDDLE: quantum_w = middle_q_reg;
                        default:    quantum_w = low_q_reg;
                    endcase
                    res_id       = job_id_w;
                    res_lvl      = job_lvl_w;
                    cur_id_next  = job_id_w;
                    cur_lvl_next = job_lvl_w;
                    used_next    = used_inc;
                    if (job_rem_w <= 8'd1) begin
                        // last slice: the job leaves
                        res_done     = 1'b1;
                        busy_next    = 1'b0;
                        cur_rem_next = '0;
                    end else begin
                        cur_rem_next = job_rem_w - 8'd1;
                        busy_next    = 1'b1;
                        if (used_inc >= quantum_w) begin
                            // quantum spent: demote behind this run's arrivals
                            dem_lvl   = (job_lvl_w == LVL_HIGH) ? LVL_MIDDLE : LVL_LOW;
                            busy_next = 1'b0;
                            q_ctrl[dem_lvl].push = 1'b1;
                            q_push_data[dem_lvl] = '{id: job_id_w,
                                                     remaining: job_rem_w - 8'd1};
                            if (q_stat[dem_lvl].full && !q_ctrl[dem_lvl].pop) begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_q_reg   <= 4'd1;
            middle_q_reg <= 4'd2;
            low_q_reg    <= 4'd3;
            busy_reg     <= 1'b0;
            cur_id_reg   <= '0;
            cur_rem_reg  <= '0;
            cur_lvl_reg  <= LVL_HIGH;
            used_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_HIGH_QUANTUM:   high_q_reg   <= cfg_data;
                    CFG_MIDDLE_QUANTUM: middle_q_reg <= cfg_data;
                    CFG_LOW_QUANTUM:    low_q_reg    <= cfg_data;
                    default:            ;            // ignore unknown index
                endcase
            end
            busy_reg    <= busy_next;
            cur_id_reg  <= cur_id_next;
            cur_rem_reg <= cur_rem_next;
            cur_lvl_reg <= cur_lvl_next;
            used_reg    <= used_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload: load on every tick beat
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_id_reg   <= res_id;
            m_idle_reg <= res_idle;
            m_lvl_reg  <= res_lvl;
            m_done_reg <= res_done;
            m_ovf_reg  <= ovf_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_served_id    = m_id_reg;
    assign m_idle         = m_idle_reg;
    assign m_served_level = m_lvl_reg;
    assign m_job_done     = m_done_reg;
    assign m_overflow     = m_ovf_reg;

    // a job held on the server always has slices left
    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cur_rem_reg != 8'd0))
        else $error("server busy with no remaining slices");

    // a tick with nothing queued and a free server reports idle
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_req_type == REQ_TICK) && !busy_reg && q_stat[LVL_HIGH].empty
         && q_stat[LVL_MIDDLE].empty && q_stat[LVL_LOW].empty)
        |=> (m_valid && m_idle && !m_job_done && (m_served_id == 8'd0)))
        else $error("empty tick did not report idle");

    // an idle result never carries a finished job and reports the high level
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_idle) |-> (!m_job_done && (m_served_level == LVL_HIGH)))
        else $error("idle result carries job fields");

    // the overflow flag never clears outside reset
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag dropped");

endmodule

`default_nettype wire

FILE: test/tb_multilevel_feedback_scheduler.sv
module tb_multilevel_feedback_scheduler;
    import mlfs_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    localparam int MAX_WAIT      = 18;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 160;
    localparam int CYCLE_LIMIT   = 600000;

    // cfg_index value that maps to no register; the block must ignore it
    localparam logic [1:0] CFG_NO_REGISTER = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] job_id;
        logic [7:0] service_slices;
        logic [1:0] job_level;
    } sched_beat_t;

    typedef struct packed {
        logic [7:0] served_id;
        logic       idle;
        logic [1:0] served_level;
        logic       job_done;
        logic       overflow;
    } slice_report_t;

    logic       aclk;
    logic       aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = REQ_ARRIVAL;
    logic [7:0] s_job_id = '0;
    logic [7:0] s_service_slices = '0;
    logic [1:0] s_job_level = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_served_id;
    logic       m_idle;
    logic [1:0] m_served_level;
    logic       m_job_done;
    logic       m_overflow;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    multilevel_feedback_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_job_id         (s_job_id),
        .s_service_slices (s_service_slices),
        .s_job_level      (s_job_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_served_id      (m_served_id),
        .m_idle           (m_idle),
        .m_served_level   (m_served_level),
        .m_job_done       (m_job_done),
        .m_overflow       (m_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scheduler mirror: three job queues, the job on the server and the
    // quantum registers, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    entry_t     high_jobs[$];
    entry_t     middle_jobs[$];
    entry_t     low_jobs[$];
    entry_t     run_job     = '0;
    level_t     run_level   = LVL_HIGH;
    logic [3:0] run_count   = '0;
    logic       on_server   = 1'b0;
    logic       drop_seen   = 1'b0;
    logic [3:0] quantum_hi  = 4'd1;
    logic [3:0] quantum_mid = 4'd2;
    logic [3:0] quantum_lo  = 4'd3;

    sched_beat_t   queued_beats[$];   // beats waiting for the driver
    slice_report_t due_reports[$];    // tick reports not yet seen on m_
    sched_beat_t   live_beat = '0;    // beat currently on the s_ bus

    int  beats_loaded = 0;
    int  beats_taken  = 0;
    int  s_hold       = 0;
    int  m_hold       = 0;
    int  cycle_count  = 0;
    int  errors       = 0;
    bit  pace_on      = 1'b1;

    int  n_ticks = 0, n_idle = 0, n_done = 0, n_requeued = 0, n_dropped = 0;
    int  n_writes = 0;

    function automatic logic [3:0] quantum_for(input level_t lvl);
        case (lvl)
            LVL_HIGH:   return quantum_hi;
            LVL_MIDDLE: return quantum_mid;
            default:    return quantum_lo;
        endcase
    endfunction

    // Drop the job and raise the sticky flag when its queue is full.
    task automatic enqueue_job(input level_t lvl, input entry_t job);
        int fill;
        case (lvl)
            LVL_HIGH:   fill = high_jobs.size();
            LVL_MIDDLE: fill = middle_jobs.size();
            default:    fill = low_jobs.size();
        endcase
        if (fill >= QUEUE_DEPTH) begin
            drop_seen = 1'b1;
            n_dropped++;
        end else begin
            case (lvl)
                LVL_HIGH:   high_jobs.push_back(job);
                LVL_MIDDLE: middle_jobs.push_back(job);
                default:    low_jobs.push_back(job);
            endcase
        end
    endtask

    task automatic serve_beat(input sched_beat_t beat);
        slice_report_t report;
        level_t        lvl;
        if (beat.req_type == REQ_ARRIVAL) begin
            // level 3 falls into the low queue
            lvl = (beat.job_level > LVL_LOW) ? LVL_LOW : level_t'(beat.job_level);
            enqueue_job(lvl, {beat.job_id, beat.service_slices});
        end else begin
            n_ticks++;
            report = '0;
            // free server: take the head of the highest non-empty queue
            if (!on_server) begin
                if (high_jobs.size() != 0) begin
                    run_job   = high_jobs.pop_front();
                    run_level = LVL_HIGH;
                    on_server = 1'b1;
                end else if (middle_jobs.size() != 0) begin
                    run_job   = middle_jobs.pop_front();
                    run_level = LVL_MIDDLE;
                    on_server = 1'b1;
                end else if (low_jobs.size() != 0) begin
                    run_job   = low_jobs.pop_front();
                    run_level = LVL_LOW;
                    on_server = 1'b1;
                end
                if (on_server) run_count = '0;
            end
            if (on_server) begin
                run_count           = run_count + 4'd1;
                report.served_id    = run_job.id;
                report.served_level = run_level;
                // zero slices behaves as one: the job leaves on its first slice
                if (run_job.remaining <= 8'd1) begin
                    report.job_done   = 1'b1;
                    run_job.remaining = '0;
                    on_server         = 1'b0;
                    n_done++;
                end else begin
                    run_job.remaining = run_job.remaining - 8'd1;
                    // quantum read at this tick; zero acts as one
                    if (run_count >= quantum_for(run_level)) begin
                        enqueue_job((run_level == LVL_HIGH) ? LVL_MIDDLE : LVL_LOW, run_job);
                        on_server = 1'b0;
                        n_requeued++;
                    end
                end
            end else begin
                report.idle = 1'b1;
                n_idle++;
            end
            report.overflow = drop_seen;
            due_reports.push_back(report);
        end
    endtask

    // Slices still owed to queued jobs and the job on the server.
    function automatic int backlog_slices();
        int total;
        total = 0;
        foreach (high_jobs[i])
            total += (high_jobs[i].remaining == 0) ? 1 : high_jobs[i].remaining;
        foreach (middle_jobs[i])
            total += (middle_jobs[i].remaining == 0) ? 1 : middle_jobs[i].remaining;
        foreach (low_jobs[i])
            total += (low_jobs[i].remaining == 0) ? 1 : low_jobs[i].remaining;
        if (on_server) total += run_job.remaining;
        return total;
    endfunction

    // Wait length for one beat: often zero, so unbroken stretches occur too.
    function automatic int draw_wait();
        if (!pace_on || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [7:0] pick_slices();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8'd0;
        if (r < 8) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic add_beat(input logic req, input logic [7:0] id,
                            input logic [7:0] slices, input logic [1:0] lvl);
        queued_beats.push_back('{req_type: req, job_id: id, service_slices: slices,
                                 job_level: lvl});
        beats_loaded++;
    endtask

    // Random beats; arrival_pct 0 gives pure ticks with random unused fields.
    task automatic add_random_beats(input int count, input int arrival_pct);
        logic req;
        for (int i = 0; i < count; i++) begin
            req = ($urandom_range(0, 99) < arrival_pct) ? REQ_ARRIVAL : REQ_TICK;
            add_beat(req, 8'($urandom_range(0, 255)), pick_slices(),
                     2'($urandom_range(0, 3)));
        end
    endtask

    // Caller stands just after a rising edge; leaves cfg_valid high.
    task automatic write_quantum(input logic [1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HIGH_QUANTUM:   quantum_hi  = val;
            CFG_MIDDLE_QUANTUM: quantum_mid = val;
            CFG_LOW_QUANTUM:    quantum_lo  = val;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic set_quanta(input logic [3:0] hi, input logic [3:0] mid,
                              input logic [3:0] lo);
        write_quantum(CFG_NO_REGISTER, 4'($urandom_range(0, 15)));
        write_quantum(CFG_HIGH_QUANTUM, hi);
        write_quantum(CFG_MIDDLE_QUANTUM, mid);
        write_quantum(CFG_LOW_QUANTUM, lo);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every beat is in and every report is back.
    task automatic wait_for_reports();
        while (beats_taken != beats_loaded || due_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: take the next beat from queued_beats once the bus is free,
    // after the drawn wait; predict on acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                serve_beat(live_beat);
                beats_taken++;
                s_hold = draw_wait();
            end
            // hold the payload while a beat is stalled
            if (!s_valid || s_ready) begin
                if (s_hold > 0) begin
                    s_hold--;
                    s_valid <= 1'b0;
                end else if (queued_beats.size() != 0) begin
                    live_beat         = queued_beats.pop_front();
                    s_valid          <= 1'b1;
                    s_req_type       <= live_beat.req_type;
                    s_job_id         <= live_beat.job_id;
                    s_service_slices <= live_beat.service_slices;
                    s_job_level      <= live_beat.job_level;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted report against the oldest prediction,
    // then drop m_ready for the drawn stall.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        slice_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected report, expected none, got id %0d idle %0b",
                             $time, m_served_id, m_idle);
                end else begin
                    want = due_reports.pop_front();
                    compare_field("served_id", want.served_id, m_served_id);
                    compare_field("idle", want.idle, m_idle);
                    compare_field("served_level", want.served_level, m_served_level);
                    compare_field("job_done", want.job_done, m_job_done);
                    compare_field("overflow", want.overflow, m_overflow);
                end
                m_hold = draw_wait();
            end
            if (m_hold > 0) begin
                m_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d beats of %0d taken, %0d reports due",
                     $time, cycle_count, beats_taken, beats_loaded, due_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed beats at reset quanta, random phases with
    // quantum changes between them, then a queue overflow phase.
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle tick, zero slices, 255 slices, level 3, all levels
        add_beat(REQ_TICK, 8'h00, 8'h00, 2'd0);
        add_beat(REQ_ARRIVAL, 8'hFF, 8'd0, LVL_HIGH);
        add_beat(REQ_ARRIVAL, 8'h00, 8'hFF, LVL_MIDDLE);
        add_beat(REQ_ARRIVAL, 8'hA5, 8'd3, 2'd3);
        add_beat(REQ_ARRIVAL, 8'h5A, 8'd2, LVL_LOW);
        add_beat(REQ_ARRIVAL, 8'h01, 8'd4, LVL_HIGH);
        add_beat(REQ_ARRIVAL, 8'h80, 8'd1, LVL_MIDDLE);
        for (int i = 0; i < 14; i++) begin
            if (i % 2 == 0) add_beat(REQ_TICK, 8'hFF, 8'hFF, 2'd3);
            else            add_beat(REQ_TICK, 8'h00, 8'h00, 2'd0);
        end
        wait_for_reports();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            case (phase)
                1: set_quanta(4'd15, 4'd15, 4'd15);
                2: set_quanta(4'd0, 4'd0, 4'd0);
                3: set_quanta(4'd1, 4'd1, 4'd1);
                4: set_quanta(4'd15, 4'd1, 4'd0);
                default: set_quanta(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
            endcase
            pace_on = (phase % 3 != 0);
            add_random_beats(PHASE_BEATS, $urandom_range(10, 20));
            wait_for_reports();
            // on odd phases drain the backlog; even phases leave a job running
            // so the next quantum write lands mid-run
            if (phase % 2 == 1) begin
                add_random_beats(backlog_slices() + 3, 0);
                wait_for_reports();
            end
        end

        // empty every queue and free the server before the overflow phase
        add_random_beats(backlog_slices() + 3, 0);
        wait_for_reports();

        // overflow: fill middle, demote a high job into it, then flood
        set_quanta(4'd1, 4'd2, 4'd3);
        pace_on = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            add_beat(REQ_ARRIVAL, 8'($urandom_range(0, 255)), 8'd1, LVL_MIDDLE);
        add_beat(REQ_ARRIVAL, 8'hC3, 8'd5, LVL_HIGH);
        add_beat(REQ_TICK, 8'h00, 8'h00, 2'd0);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            add_beat(REQ_ARRIVAL, 8'($urandom_range(0, 255)), 8'd1, LVL_HIGH);
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            add_beat(REQ_ARRIVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 2)),
                     2'($urandom_range(2, 3)));
        wait_for_reports();
        add_random_beats(backlog_slices() + 3, 0);
        add_random_beats(100, 20);
        wait_for_reports();

        if (due_reports.size() != 0) begin
            errors++;
            $display("%0t: %0d reports still expected, got none", $time, due_reports.size());
        end
        $display("Run covered %0d beats: %0d ticks, %0d idle, %0d jobs done, %0d requeued",
                 beats_taken, n_ticks, n_idle, n_done, n_requeued);
        $display("%0d jobs dropped on full queues, %0d quantum writes, %0d mismatches",
                 n_dropped, n_writes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
